[hw/rtl/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and codes of the I2C master transfer sequencer
// Holds the word layouts of both channels, the per-item result bundle and
// the sequencer state, plus the action, result and error codes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // action codes of an input word
  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_EVENT = 2'd1;
  localparam logic [1:0] ACT_ERROR = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CTRL   = 2'd0;
  localparam logic [1:0] KIND_RX     = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_TIMED_OUT = 3'd1;
  localparam logic [2:0] ERR_OVERRUN   = 3'd2;
  localparam logic [2:0] ERR_NAK       = 3'd3;
  localparam logic [2:0] ERR_ARBIT     = 3'd4;
  localparam logic [2:0] ERR_BUS       = 3'd5;
  localparam logic [2:0] ERR_NO_FLAG   = 3'd6;
  localparam logic [2:0] ERR_BAD_BEGIN = 3'd7;

  // status flag bit positions
  localparam int SR_SB      = 0;
  localparam int SR_ADDR    = 1;
  localparam int SR_BTF     = 2;
  localparam int SR_RXNE    = 3;
  localparam int SR_TXE     = 4;
  localparam int SR_TIMEOUT = 5;
  localparam int SR_OVR     = 6;
  localparam int SR_AF      = 7;
  localparam int SR_ARLO    = 8;
  localparam int SR_BERR    = 9;

  // transfer lengths with paths of their own
  localparam logic [7:0] LEN_ONE   = 8'd1;
  localparam logic [7:0] LEN_TWO   = 8'd2;
  localparam logic [7:0] LEN_THREE = 8'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] target_address;
    logic       read_not_write;
    logic [7:0] length;
    logic       send_start;
    logic       send_stop;
    logic [9:0] status_flags;
    logic [7:0] data_first;
    logic [7:0] data_second;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] data_value;
    logic       write_data_valid;
    logic       ack_enable;
    logic       nack_next;
    logic       issue_start;
    logic       issue_stop;
    logic       buffer_irq_enable;
    logic       event_irq_enable;
    logic [2:0] error_code;
    logic [7:0] bytes_left;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       bus_started;
    logic [7:0] address_byte;
    logic [7:0] transfer_length;
    logic [7:0] remaining;
    logic       stop_requested;
    logic       ack_bit;
    logic       pos_bit;
    logic       buffer_irq_bit;
    logic       event_irq_bit;
    logic [2:0] last_error;
  } seq_state_t;

  // everything one input word produces: received bytes, then a closing word
  typedef struct packed {
    logic [1:0]      nrx;
    logic [1:0][7:0] rx_data;
    logic [1:0][7:0] rx_left;
    logic [1:0]      kind;
    logic [7:0]      data;
    logic            wdv;
    logic            start;
    logic            stop;
    logic [2:0]      err;
    logic [7:0]      left;
    logic            ack;
    logic            pos;
    logic            birq;
    logic            eirq;
  } bundle_t;

  function automatic logic [7:0] dec_sat(input logic [7:0] v);
    return (v != 8'd0) ? v - 8'd1 : v;
  endfunction

endpackage

[hw/rtl/i2cm_if.sv]
// ----------------------------------------------------------------------------
// i2cm_in_if / i2cm_out_if: valid/ready channels of the sequencer
// One interface per direction, each with a source and a sink view.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic               valid;
  logic               ready;
  i2cm_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface i2cm_out_if;
  logic                valid;
  logic                ready;
  i2cm_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

[hw/rtl/i2cm_step.sv]
// ----------------------------------------------------------------------------
// i2cm_step: sequencer state and one-word decision logic
// Decides the results of the registered input word and holds the state,
// which advances when the word is handed to the result buffer.
// ----------------------------------------------------------------------------
module i2cm_step #(
  parameter int MAX_LENGTH = 255
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  i2cm_pkg::in_item_t item,
  output i2cm_pkg::bundle_t  bundle
);

  i2cm_pkg::seq_state_t st;
  i2cm_pkg::seq_state_t st_next;
  logic sb, adr, btf, rxne, txe, too_long;

  assign sb   = item.status_flags[i2cm_pkg::SR_SB];
  assign adr  = item.status_flags[i2cm_pkg::SR_ADDR];
  assign btf  = item.status_flags[i2cm_pkg::SR_BTF];
  assign rxne = item.status_flags[i2cm_pkg::SR_RXNE];
  assign txe  = item.status_flags[i2cm_pkg::SR_TXE];
  assign too_long = 32'(item.length) > 32'(MAX_LENGTH);

  always_comb begin
    st_next = st;
    bundle  = '0;
    if (item.action == i2cm_pkg::ACT_BEGIN) begin
      if ((item.read_not_write && (item.length == 8'd0 || !item.send_start)) || too_long) begin
        if (st.bus_started) begin
          st_next.buffer_irq_bit = 1'b0;
          st_next.event_irq_bit  = 1'b0;
          st_next.ack_bit        = 1'b0;
          st_next.pos_bit        = 1'b0;
          st_next.bus_started    = 1'b0;
          bundle.stop            = 1'b1;
        end
        st_next.last_error = i2cm_pkg::ERR_BAD_BEGIN;
        bundle.kind = i2cm_pkg::KIND_FINISH;
        bundle.err  = i2cm_pkg::ERR_BAD_BEGIN;
      end else begin
        st_next.last_error      = i2cm_pkg::ERR_OK;
        st_next.transfer_length = item.length;
        st_next.remaining       = item.length;
        st_next.address_byte    = {item.target_address, item.read_not_write};
        st_next.stop_requested  = item.send_stop;
        st_next.pos_bit         = 1'b0;
        st_next.ack_bit         = 1'b1;
        if (item.read_not_write || item.send_start || !st.bus_started) begin
          bundle.start        = 1'b1;
          st_next.bus_started = 1'b1;
        end else begin
          st_next.buffer_irq_bit = 1'b1;
        end
        st_next.event_irq_bit = 1'b1;
      end
    end else if (item.action == i2cm_pkg::ACT_EVENT && st.event_irq_bit) begin
      if (sb) begin
        bundle.data = st.address_byte;
        bundle.wdv  = 1'b1;
      end else if (st.address_byte[0]) begin
        if (st.transfer_length == i2cm_pkg::LEN_ONE) begin
          if (adr) begin
            st_next.ack_bit = 1'b0;
            if (st.stop_requested) begin
              bundle.stop = 1'b1;
              st_next.bus_started = 1'b0;
            end
            st_next.buffer_irq_bit = 1'b1;
          end else if (rxne) begin
            st_next.remaining = i2cm_pkg::dec_sat(st.remaining);
            bundle.nrx        = 2'd1;
            bundle.rx_data[0] = item.data_first;
            bundle.rx_left[0] = st_next.remaining;
            st_next.buffer_irq_bit = 1'b0;
            st_next.event_irq_bit  = 1'b0;
            bundle.kind = i2cm_pkg::KIND_FINISH;
            bundle.err  = st.last_error;
          end
        end else if (st.transfer_length == i2cm_pkg::LEN_TWO) begin
          if (adr) begin
            st_next.pos_bit = 1'b1;
            st_next.ack_bit = 1'b0;
          end else if (btf) begin
            if (st.stop_requested) begin
              bundle.stop = 1'b1;
              st_next.bus_started = 1'b0;
            end
            bundle.nrx        = 2'd2;
            bundle.rx_data[0] = item.data_first;
            bundle.rx_left[0] = i2cm_pkg::dec_sat(st.remaining);
            bundle.rx_data[1] = item.data_second;
            bundle.rx_left[1] = i2cm_pkg::dec_sat(bundle.rx_left[0]);
            st_next.remaining = bundle.rx_left[1];
            st_next.buffer_irq_bit = 1'b0;
            st_next.event_irq_bit  = 1'b0;
            bundle.kind = i2cm_pkg::KIND_FINISH;
            bundle.err  = st.last_error;
          end
        end else begin
          if (adr) begin
            st_next.buffer_irq_bit = 1'b1;
          end else if (st.buffer_irq_bit && rxne) begin
            if (st.remaining == i2cm_pkg::LEN_THREE) begin
              // hold the third-last byte so that BTF takes it with the second-last
              st_next.buffer_irq_bit = 1'b0;
            end else begin
              st_next.remaining = i2cm_pkg::dec_sat(st.remaining);
              bundle.nrx        = 2'd1;
              bundle.rx_data[0] = item.data_first;
              bundle.rx_left[0] = st_next.remaining;
              if (st.remaining == i2cm_pkg::LEN_ONE) begin
                st_next.buffer_irq_bit = 1'b0;
                st_next.event_irq_bit  = 1'b0;
                bundle.kind = i2cm_pkg::KIND_FINISH;
                bundle.err  = st.last_error;
              end
            end
          end else if (!st.buffer_irq_bit && btf) begin
            st_next.ack_bit = 1'b0;
            if (st.stop_requested) begin
              bundle.stop = 1'b1;
              st_next.bus_started = 1'b0;
            end
            bundle.nrx        = 2'd2;
            bundle.rx_data[0] = item.data_first;
            bundle.rx_left[0] = i2cm_pkg::dec_sat(st.remaining);
            bundle.rx_data[1] = item.data_second;
            bundle.rx_left[1] = i2cm_pkg::dec_sat(bundle.rx_left[0]);
            st_next.remaining = bundle.rx_left[1];
            st_next.buffer_irq_bit = 1'b1;
          end
        end
      end else begin
        if (adr) begin
          if (st.remaining != 8'd0) begin
            bundle.data = item.data_first;
            bundle.wdv  = 1'b1;
            st_next.remaining = st.remaining - 8'd1;
          end
          if (st_next.remaining != 8'd0) begin
            st_next.buffer_irq_bit = 1'b1;
          end else begin
            if (st.stop_requested) begin
              bundle.stop = 1'b1;
              st_next.bus_started = 1'b0;
            end
            st_next.buffer_irq_bit = 1'b0;
            st_next.event_irq_bit  = 1'b0;
            bundle.kind = i2cm_pkg::KIND_FINISH;
            bundle.err  = st.last_error;
          end
        end else if (st.buffer_irq_bit && txe) begin
          bundle.data = item.data_first;
          bundle.wdv  = 1'b1;
          st_next.remaining = i2cm_pkg::dec_sat(st.remaining);
          if (st_next.remaining == 8'd0) begin
            st_next.buffer_irq_bit = 1'b0;
          end
        end else if (!st.buffer_irq_bit && btf) begin
          if (st.stop_requested) begin
            bundle.stop = 1'b1;
            st_next.bus_started = 1'b0;
          end
          st_next.buffer_irq_bit = 1'b0;
          st_next.event_irq_bit  = 1'b0;
          bundle.kind = i2cm_pkg::KIND_FINISH;
          bundle.err  = st.last_error;
        end
      end
    end else if (item.action == i2cm_pkg::ACT_ERROR && st.event_irq_bit) begin
      priority if (item.status_flags[i2cm_pkg::SR_TIMEOUT]) begin
        st_next.last_error  = i2cm_pkg::ERR_TIMED_OUT;
        st_next.bus_started = 1'b0;
      end else if (item.status_flags[i2cm_pkg::SR_OVR]) begin
        st_next.last_error  = i2cm_pkg::ERR_OVERRUN;
        st_next.bus_started = 1'b0;
      end else if (item.status_flags[i2cm_pkg::SR_AF]) begin
        st_next.last_error  = i2cm_pkg::ERR_NAK;
        st_next.bus_started = 1'b0;
        bundle.stop         = 1'b1;
      end else if (item.status_flags[i2cm_pkg::SR_ARLO]) begin
        st_next.last_error  = i2cm_pkg::ERR_ARBIT;
        st_next.bus_started = 1'b0;
      end else if (item.status_flags[i2cm_pkg::SR_BERR]) begin
        st_next.last_error  = i2cm_pkg::ERR_BUS;
        st_next.bus_started = 1'b0;
      end else begin
        st_next.last_error  = i2cm_pkg::ERR_NO_FLAG;
      end
      st_next.buffer_irq_bit = 1'b0;
      st_next.event_irq_bit  = 1'b0;
      st_next.pos_bit        = 1'b0;
      bundle.kind = i2cm_pkg::KIND_FINISH;
      bundle.err  = st_next.last_error;
    end
    bundle.left = st_next.remaining;
    bundle.ack  = st_next.ack_bit;
    bundle.pos  = st_next.pos_bit;
    bundle.birq = st_next.buffer_irq_bit;
    bundle.eirq = st_next.event_irq_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

[hw/rtl/i2cm_result_buf.sv]
// ----------------------------------------------------------------------------
// i2cm_result_buf: result register and output sequencing
// Holds one result bundle and presents its words one per cycle while the sink
// is ready, received bytes first, closing word last.
// ----------------------------------------------------------------------------
module i2cm_result_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  i2cm_pkg::bundle_t   bundle_in,
  output logic                free,
  i2cm_out_if.source          out_ch
);

  i2cm_pkg::bundle_t bundle;
  logic       valid;
  logic [1:0] idx;
  logic       take;
  logic       is_last;

  assign take    = valid && out_ch.ready;
  assign is_last = (idx == bundle.nrx);
  assign free    = !valid || (take && is_last);
  assign out_ch.valid = valid;

  always_comb begin
    out_ch.item = '0;
    out_ch.item.ack_enable        = bundle.ack;
    out_ch.item.nack_next         = bundle.pos;
    out_ch.item.buffer_irq_enable = bundle.birq;
    out_ch.item.event_irq_enable  = bundle.eirq;
    if (is_last) begin
      out_ch.item.result_kind      = bundle.kind;
      out_ch.item.data_value       = bundle.data;
      out_ch.item.write_data_valid = bundle.wdv;
      out_ch.item.issue_start      = bundle.start;
      out_ch.item.issue_stop       = bundle.stop;
      out_ch.item.error_code       = bundle.err;
      out_ch.item.bytes_left       = bundle.left;
      out_ch.item.last             = 1'b1;
    end else begin
      out_ch.item.result_kind = i2cm_pkg::KIND_RX;
      out_ch.item.data_value  = bundle.rx_data[idx[0]];
      out_ch.item.bytes_left  = bundle.rx_left[idx[0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (take) begin
      if (is_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bundle <= bundle_in;
    end
  end

endmodule

[hw/rtl/i2c_master_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer: master-side I2C transfer sequencer
// Turns begin, peripheral-event and error-event words into control
// updates, received bytes and completion records for one transfer.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake        | word
//   ---------+-----+------------------+---------------------------------
//   in_ch    | in  | valid / ready    | begin, peripheral or error event
//   out_ch   | out | valid / ready    | control, received byte, finish
//
// Each input word gives one to three output words; the closing word carries
// last. A word is taken into the input register, decided combinationally and
// moved to the result register once it frees, from which the first result is
// offered. A word with n results holds the result register until all n of its
// words are taken; with one result per word and a ready output the block
// sustains one word per cycle. Reset clears the sequencer state and both valid
// flags. A stalled output holds the result register, and the input register
// then holds the next word until the result register frees.
//
module i2c_master_transfer_sequencer #(
  parameter int MAX_LENGTH = 255
) (
  input  logic       clk,
  input  logic       rst,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch
);

  i2cm_pkg::in_item_t in_q;
  logic               in_q_valid;
  i2cm_pkg::bundle_t  bundle;
  logic               buf_free;
  logic               fire;

  // advance the registered word into the result register when it frees
  assign fire        = in_q_valid && buf_free;
  assign in_ch.ready = !in_q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q <= in_ch.item;
    end
  end

  i2cm_step #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_q),
    .bundle (bundle)
  );

  i2cm_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .bundle_in (bundle),
    .free      (buf_free),
    .out_ch    (out_ch)
  );

  // a received byte is never the closing word
  a_rx_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.item.result_kind == i2cm_pkg::KIND_RX) |-> !out_ch.item.last)
    else $error("received-byte word marked last");

  // the last word taken with nothing decided leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.item.last && !fire) |=> !out_ch.valid)
    else $error("output valid after last word drained");

  // a waiting input word holds until it is decided
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !fire) |=> (in_q_valid && $stable(in_q)))
    else $error("pending input word lost or changed");

endmodule

[tb/tb_i2c_master_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_i2c_master_transfer_sequencer: self-checking bench of the I2C sequencer
// Plays directed and random begin, peripheral-event and error-event words
// into the sequencer under random source gaps and sink stalls. Every input
// word is run through a local transfer predictor, and each result word is
// compared field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_i2c_master_transfer_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LENGTH = 255;

  // action 3 has no meaning in the block; it must be ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // status flag words used by the transfer generators
  localparam logic [9:0] FLAG_SB   = 10'b1 << i2cm_pkg::SR_SB;
  localparam logic [9:0] FLAG_ADDR = 10'b1 << i2cm_pkg::SR_ADDR;
  localparam logic [9:0] FLAG_BTF  = 10'b1 << i2cm_pkg::SR_BTF;
  localparam logic [9:0] FLAG_RXNE = 10'b1 << i2cm_pkg::SR_RXNE;
  localparam logic [9:0] FLAG_TXE  = 10'b1 << i2cm_pkg::SR_TXE;
  localparam logic [9:0] FLAG_AF   = 10'b1 << i2cm_pkg::SR_AF;
  localparam logic [9:0] FLAG_ALL  = '1;

  localparam int STIM_WORDS    = 470;   // stop generating near this many input words
  localparam int HOLDOFF_LEN   = 300;   // long sink stall, in cycles
  localparam int IDLE_LIMIT    = 2000;  // cycles without any handshake before giving up
  localparam int TAIL_CYCLES   = 16;    // settle time after the last expected word

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_ONE_IN_FOUR,
    STALL_COIN,
    STALL_ALTERNATE
  } stall_mode_t;

  typedef struct {
    i2cm_pkg::in_item_t word;
    bit                 drain;   // hold this word back until every expected result is in
  } pending_t;

  logic clk;
  logic rst;

  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();

  i2c_master_transfer_sequencer #(.MAX_LENGTH(MAX_LENGTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Transfer predictor: own copy of the sequencer state and the words it owes
  // --------------------------------------------------------------------------
  i2cm_pkg::seq_state_t seq;
  i2cm_pkg::out_item_t  expected_words[$];
  logic [7:0]           received_bytes[$];
  logic [7:0]           received_left[$];

  // Take one received byte: count down (never below zero) and note the byte.
  function automatic void take_byte(input logic [7:0] b);
    if (seq.remaining != 8'd0) seq.remaining = seq.remaining - 8'd1;
    received_bytes.push_back(b);
    received_left.push_back(seq.remaining);
  endfunction

  // Advance the predicted state by one accepted word and queue the results.
  function automatic void predict_transfer_step(input i2cm_pkg::in_item_t w);
    logic [1:0]          kind;
    logic [7:0]          data;
    logic                wdv, st, sp;
    logic [2:0]          err;
    logic                sb, adr, btf, rxne, txe;
    i2cm_pkg::out_item_t o;
    kind = i2cm_pkg::KIND_CTRL;
    data = 8'd0;
    wdv  = 1'b0;
    st   = 1'b0;
    sp   = 1'b0;
    err  = i2cm_pkg::ERR_OK;
    sb   = w.status_flags[i2cm_pkg::SR_SB];
    adr  = w.status_flags[i2cm_pkg::SR_ADDR];
    btf  = w.status_flags[i2cm_pkg::SR_BTF];
    rxne = w.status_flags[i2cm_pkg::SR_RXNE];
    txe  = w.status_flags[i2cm_pkg::SR_TXE];
    received_bytes.delete();
    received_left.delete();

    if (w.action == i2cm_pkg::ACT_BEGIN) begin
      if ((w.read_not_write && (w.length == 8'd0 || !w.send_start)) ||
          int'(w.length) > MAX_LENGTH) begin
        // rejected begin: abort a running transfer with a stop
        if (seq.bus_started) begin
          seq.buffer_irq_bit = 1'b0;
          seq.event_irq_bit  = 1'b0;
          seq.ack_bit        = 1'b0;
          seq.pos_bit        = 1'b0;
          sp                 = 1'b1;
          seq.bus_started    = 1'b0;
        end
        seq.last_error = i2cm_pkg::ERR_BAD_BEGIN;
        kind           = i2cm_pkg::KIND_FINISH;
        err            = i2cm_pkg::ERR_BAD_BEGIN;
      end else begin
        seq.last_error      = i2cm_pkg::ERR_OK;
        seq.transfer_length = w.length;
        seq.remaining       = w.length;
        seq.address_byte    = {w.target_address, w.read_not_write};
        seq.stop_requested  = w.send_stop;
        seq.pos_bit         = 1'b0;
        seq.ack_bit         = 1'b1;
        // a write that continues on a started bus skips the start condition
        if (w.read_not_write || w.send_start || !seq.bus_started) begin
          st              = 1'b1;
          seq.bus_started = 1'b1;
        end else begin
          seq.buffer_irq_bit = 1'b1;
        end
        seq.event_irq_bit = 1'b1;
      end
    end else if (w.action == i2cm_pkg::ACT_EVENT && seq.event_irq_bit) begin
      if (sb) begin
        data = seq.address_byte;
        wdv  = 1'b1;
      end else if (seq.address_byte[0]) begin
        if (seq.transfer_length == i2cm_pkg::LEN_ONE) begin
          if (adr) begin
            seq.ack_bit = 1'b0;
            if (seq.stop_requested) begin
              sp              = 1'b1;
              seq.bus_started = 1'b0;
            end
            seq.buffer_irq_bit = 1'b1;
          end else if (rxne) begin
            take_byte(w.data_first);
            seq.buffer_irq_bit = 1'b0;
            seq.event_irq_bit  = 1'b0;
            kind               = i2cm_pkg::KIND_FINISH;
            err                = seq.last_error;
          end
        end else if (seq.transfer_length == i2cm_pkg::LEN_TWO) begin
          if (adr) begin
            seq.pos_bit = 1'b1;
            seq.ack_bit = 1'b0;
          end else if (btf) begin
            if (seq.stop_requested) begin
              sp              = 1'b1;
              seq.bus_started = 1'b0;
            end
            take_byte(w.data_first);
            take_byte(w.data_second);
            seq.buffer_irq_bit = 1'b0;
            seq.event_irq_bit  = 1'b0;
            kind               = i2cm_pkg::KIND_FINISH;
            err                = seq.last_error;
          end
        end else begin
          // N-byte read: three left stops the buffer interrupt, btf takes two
          if (adr) begin
            seq.buffer_irq_bit = 1'b1;
          end else if (seq.buffer_irq_bit && rxne) begin
            if (seq.remaining == i2cm_pkg::LEN_THREE) begin
              seq.buffer_irq_bit = 1'b0;
            end else if (seq.remaining == i2cm_pkg::LEN_ONE) begin
              take_byte(w.data_first);
              seq.buffer_irq_bit = 1'b0;
              seq.event_irq_bit  = 1'b0;
              kind               = i2cm_pkg::KIND_FINISH;
              err                = seq.last_error;
            end else begin
              take_byte(w.data_first);
            end
          end else if (!seq.buffer_irq_bit && btf) begin
            seq.ack_bit = 1'b0;
            take_byte(w.data_first);
            if (seq.stop_requested) begin
              sp              = 1'b1;
              seq.bus_started = 1'b0;
            end
            take_byte(w.data_second);
            seq.buffer_irq_bit = 1'b1;
          end
        end
      end else begin
        if (adr) begin
          if (seq.remaining != 8'd0) begin
            data          = w.data_first;
            wdv           = 1'b1;
            seq.remaining = seq.remaining - 8'd1;
          end
          if (seq.remaining != 8'd0) begin
            seq.buffer_irq_bit = 1'b1;
          end else begin
            if (seq.stop_requested) begin
              sp              = 1'b1;
              seq.bus_started = 1'b0;
            end
            seq.buffer_irq_bit = 1'b0;
            seq.event_irq_bit  = 1'b0;
            kind               = i2cm_pkg::KIND_FINISH;
            err                = seq.last_error;
          end
        end else if (seq.buffer_irq_bit && txe) begin
          data = w.data_first;
          wdv  = 1'b1;
          if (seq.remaining != 8'd0) seq.remaining = seq.remaining - 8'd1;
          if (seq.remaining == 8'd0) seq.buffer_irq_bit = 1'b0;
        end else if (!seq.buffer_irq_bit && btf) begin
          if (seq.stop_requested) begin
            sp              = 1'b1;
            seq.bus_started = 1'b0;
          end
          seq.buffer_irq_bit = 1'b0;
          seq.event_irq_bit  = 1'b0;
          kind               = i2cm_pkg::KIND_FINISH;
          err                = seq.last_error;
        end
      end
    end else if (w.action == i2cm_pkg::ACT_ERROR && seq.event_irq_bit) begin
      // highest-priority flag wins; nack also sends a stop
      if (w.status_flags[i2cm_pkg::SR_TIMEOUT]) begin
        seq.last_error  = i2cm_pkg::ERR_TIMED_OUT;
        seq.bus_started = 1'b0;
      end else if (w.status_flags[i2cm_pkg::SR_OVR]) begin
        seq.last_error  = i2cm_pkg::ERR_OVERRUN;
        seq.bus_started = 1'b0;
      end else if (w.status_flags[i2cm_pkg::SR_AF]) begin
        seq.last_error  = i2cm_pkg::ERR_NAK;
        sp              = 1'b1;
        seq.bus_started = 1'b0;
      end else if (w.status_flags[i2cm_pkg::SR_ARLO]) begin
        seq.last_error  = i2cm_pkg::ERR_ARBIT;
        seq.bus_started = 1'b0;
      end else if (w.status_flags[i2cm_pkg::SR_BERR]) begin
        seq.last_error  = i2cm_pkg::ERR_BUS;
        seq.bus_started = 1'b0;
      end else begin
        seq.last_error = i2cm_pkg::ERR_NO_FLAG;
      end
      seq.buffer_irq_bit = 1'b0;
      seq.event_irq_bit  = 1'b0;
      seq.pos_bit        = 1'b0;
      kind               = i2cm_pkg::KIND_FINISH;
      err                = seq.last_error;
    end

    // received bytes first, each carrying the control bits after the step
    foreach (received_bytes[i]) begin
      o                   = '0;
      o.result_kind       = i2cm_pkg::KIND_RX;
      o.data_value        = received_bytes[i];
      o.ack_enable        = seq.ack_bit;
      o.nack_next         = seq.pos_bit;
      o.buffer_irq_enable = seq.buffer_irq_bit;
      o.event_irq_enable  = seq.event_irq_bit;
      o.error_code        = i2cm_pkg::ERR_OK;
      o.bytes_left        = received_left[i];
      expected_words.push_back(o);
    end
    o                   = '0;
    o.result_kind       = kind;
    o.data_value        = data;
    o.write_data_valid  = wdv;
    o.ack_enable        = seq.ack_bit;
    o.nack_next         = seq.pos_bit;
    o.issue_start       = st;
    o.issue_stop        = sp;
    o.buffer_irq_enable = seq.buffer_irq_bit;
    o.event_irq_enable  = seq.event_irq_bit;
    o.error_code        = err;
    o.bytes_left        = seq.remaining;
    o.last              = 1'b1;
    expected_words.push_back(o);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation: words go into pending_words before the run starts
  // --------------------------------------------------------------------------
  pending_t           pending_words[$];
  i2cm_pkg::in_item_t transfer_steps[$];
  bit                 drain_next;

  function automatic i2cm_pkg::in_item_t random_word();
    i2cm_pkg::in_item_t w;
    w.action         = 2'($urandom_range(0, 3));
    w.target_address = 7'($urandom_range(0, 127));
    w.read_not_write = 1'($urandom_range(0, 1));
    w.length         = 8'($urandom_range(0, 255));
    w.send_start     = 1'($urandom_range(0, 1));
    w.send_stop      = 1'($urandom_range(0, 1));
    w.status_flags   = 10'($urandom_range(0, 1023));
    w.data_first     = 8'($urandom_range(0, 255));
    w.data_second    = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // unused fields of every word stay random
  function automatic i2cm_pkg::in_item_t mk_begin(input logic [6:0] addr,
                                                  input logic rnw,
                                                  input logic [7:0] len,
                                                  input logic start,
                                                  input logic stop);
    i2cm_pkg::in_item_t w;
    w                = random_word();
    w.action         = i2cm_pkg::ACT_BEGIN;
    w.target_address = addr;
    w.read_not_write = rnw;
    w.length         = len;
    w.send_start     = start;
    w.send_stop      = stop;
    return w;
  endfunction

  function automatic i2cm_pkg::in_item_t mk_event(input logic [9:0] flags);
    i2cm_pkg::in_item_t w;
    w              = random_word();
    w.action       = i2cm_pkg::ACT_EVENT;
    w.status_flags = flags;
    return w;
  endfunction

  function automatic i2cm_pkg::in_item_t mk_error(input logic [9:0] flags);
    i2cm_pkg::in_item_t w;
    w              = random_word();
    w.action       = i2cm_pkg::ACT_ERROR;
    w.status_flags = flags;
    return w;
  endfunction

  // single error flags, several at once, or none at all
  function automatic logic [9:0] random_error_flags();
    case ($urandom_range(0, 3))
      0:       return 10'b1 << $urandom_range(i2cm_pkg::SR_TIMEOUT, i2cm_pkg::SR_BERR);
      1:       return 10'($urandom_range(0, 1023));
      2:       return 10'd0;
      default: return (10'b1 << $urandom_range(i2cm_pkg::SR_TIMEOUT, i2cm_pkg::SR_BERR)) |
                      (10'b1 << $urandom_range(i2cm_pkg::SR_TIMEOUT, i2cm_pkg::SR_BERR));
    endcase
  endfunction

  function automatic void queue_pending(input i2cm_pkg::in_item_t w);
    pending_t p;
    p.word     = w;
    p.drain    = drain_next;
    drain_next = 1'b0;
    pending_words.push_back(p);
  endfunction

  // Emit a planned transfer, sometimes cut short by an error or dropped
  // halfway so that the next begin lands on a stale transfer.
  task automatic flush_transfer();
    int  keep;
    bit  broken;
    keep   = transfer_steps.size();
    broken = 1'b0;
    case ($urandom_range(0, 15))
      0, 1: begin
        keep   = $urandom_range(1, transfer_steps.size());
        broken = 1'b1;
      end
      2:       keep = $urandom_range(1, transfer_steps.size());
      default: ;
    endcase
    for (int i = 0; i < keep; i++) queue_pending(transfer_steps[i]);
    if (broken) queue_pending(mk_error(random_error_flags()));
  endtask

  task automatic plan_write(input logic [7:0] len, input bit with_start);
    int txe_count;
    transfer_steps.delete();
    transfer_steps.push_back(mk_begin(7'($urandom_range(0, 127)), 1'b0, len, with_start,
                                      $urandom_range(0, 3) != 0));
    txe_count = int'(len);
    if (with_start) begin
      transfer_steps.push_back(mk_event(FLAG_SB));
      transfer_steps.push_back(mk_event(FLAG_ADDR));
      txe_count = (len == 8'd0) ? 0 : int'(len) - 1;
    end
    repeat (txe_count) transfer_steps.push_back(mk_event(FLAG_TXE));
    // an empty write finishes at the address phase already
    if (!(with_start && len == 8'd0)) transfer_steps.push_back(mk_event(FLAG_BTF));
    flush_transfer();
  endtask

  task automatic plan_read(input logic [7:0] len);
    transfer_steps.delete();
    transfer_steps.push_back(mk_begin(7'($urandom_range(0, 127)), 1'b1, len, 1'b1,
                                      $urandom_range(0, 3) != 0));
    transfer_steps.push_back(mk_event(FLAG_SB));
    transfer_steps.push_back(mk_event(FLAG_ADDR));
    if (len == i2cm_pkg::LEN_ONE) begin
      transfer_steps.push_back(mk_event(FLAG_RXNE));
    end else if (len == i2cm_pkg::LEN_TWO) begin
      transfer_steps.push_back(mk_event(FLAG_BTF));
    end else begin
      // bytes down to three left, one receive-full that parks, btf, last byte
      repeat (int'(len) - 2) transfer_steps.push_back(mk_event(FLAG_RXNE));
      transfer_steps.push_back(mk_event(FLAG_BTF));
      transfer_steps.push_back(mk_event(FLAG_RXNE));
    end
    flush_transfer();
  endtask

  task automatic build_directed();
    i2cm_pkg::in_item_t w;
    // nothing running: an event and the unused action do nothing
    queue_pending(mk_event(FLAG_ALL));
    w        = random_word();
    w.action = ACT_UNUSED;
    queue_pending(w);
    // read of zero bytes is rejected, no stop since the bus is idle
    queue_pending(mk_begin(7'd0, 1'b1, 8'd0, 1'b1, 1'b1));
    // start a write at the top address, then send the address byte
    queue_pending(mk_begin(7'd127, 1'b0, 8'd1, 1'b1, 1'b0));
    queue_pending(mk_event(FLAG_SB));
    // read without start: rejected, aborts the running transfer with a stop
    queue_pending(mk_begin(7'h5a, 1'b1, 8'd4, 1'b0, 1'b1));
    queue_pending(mk_error(FLAG_AF));
    // one-byte read
    queue_pending(mk_begin(7'd0, 1'b1, 8'd1, 1'b1, 1'b1));
    queue_pending(mk_event(FLAG_SB));
    queue_pending(mk_event(FLAG_ADDR));
    w            = mk_event(FLAG_RXNE);
    w.data_first = 8'hff;
    queue_pending(w);
    // two-byte read, both bytes at btf
    queue_pending(mk_begin(7'd127, 1'b1, 8'd2, 1'b1, 1'b1));
    queue_pending(mk_event(FLAG_ADDR));
    w             = mk_event(FLAG_BTF);
    w.data_first  = 8'h00;
    w.data_second = 8'hff;
    queue_pending(w);
    // empty write finishes at the address phase
    queue_pending(mk_begin(7'h2a, 1'b0, 8'd0, 1'b1, 1'b1));
    queue_pending(mk_event(FLAG_ADDR));
    // longest write, cut by every error flag at once: timeout wins
    queue_pending(mk_begin(7'h55, 1'b0, 8'd255, 1'b1, 1'b0));
    queue_pending(mk_event(FLAG_ADDR));
    queue_pending(mk_event(FLAG_TXE));
    queue_pending(mk_error(FLAG_ALL));
    // error event without a flag leaves the bus started
    queue_pending(mk_begin(7'h11, 1'b0, 8'd3, 1'b1, 1'b1));
    queue_pending(mk_error(10'd0));
    // write continuing on the started bus: no start, buffer interrupt at once
    queue_pending(mk_begin(7'h33, 1'b0, 8'd2, 1'b0, 1'b1));
    queue_pending(mk_event(FLAG_TXE));
    // begin while that write still runs replaces it
    queue_pending(mk_begin(7'h22, 1'b1, 8'd3, 1'b1, 1'b0));
  endtask

  task automatic build_random();
    int         pick;
    logic [7:0] len;
    // first random transfer waits for the directed results to drain
    drain_next = 1'b1;
    while (pending_words.size() < STIM_WORDS) begin
      if ($urandom_range(0, 19) == 0) drain_next = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        len = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(5, 16)) :
                                            8'($urandom_range(0, 4));
        plan_write(len, $urandom_range(0, 5) != 0);
      end else if (pick < 8) begin
        case ($urandom_range(0, 5))
          0:       len = i2cm_pkg::LEN_ONE;
          1:       len = i2cm_pkg::LEN_TWO;
          2:       len = 8'($urandom_range(9, 20));
          default: len = 8'($urandom_range(3, 8));
        endcase
        plan_read(len);
      end else begin
        repeat ($urandom_range(1, 3)) queue_pending(random_word());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sampling at the rising edge: take input words, check result words, and
  // watch for a stuck run
  // --------------------------------------------------------------------------
  int mismatches;
  int words_in;
  int idle_cycles;
  bit in_taken;

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : sample
    i2cm_pkg::out_item_t want;
    bit                  moved;
    in_taken = 1'b0;
    moved    = 1'b0;
    if (!rst) begin
      // predict at acceptance; results of this word cannot arrive yet
      if (in_ch.valid && in_ch.ready) begin
        predict_transfer_step(pending_words[0].word);
        void'(pending_words.pop_front());
        in_taken = 1'b1;
        moved    = 1'b1;
        words_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: kind %0d, data %0d",
                 out_ch.item.result_kind, out_ch.item.data_value);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("result_kind", 8'(want.result_kind), 8'(out_ch.item.result_kind));
          check_field("data_value", want.data_value, out_ch.item.data_value);
          check_field("write_data_valid", 8'(want.write_data_valid),
                      8'(out_ch.item.write_data_valid));
          check_field("ack_enable", 8'(want.ack_enable), 8'(out_ch.item.ack_enable));
          check_field("nack_next", 8'(want.nack_next), 8'(out_ch.item.nack_next));
          check_field("issue_start", 8'(want.issue_start), 8'(out_ch.item.issue_start));
          check_field("issue_stop", 8'(want.issue_stop), 8'(out_ch.item.issue_stop));
          check_field("buffer_irq_enable", 8'(want.buffer_irq_enable),
                      8'(out_ch.item.buffer_irq_enable));
          check_field("event_irq_enable", 8'(want.event_irq_enable),
                      8'(out_ch.item.event_irq_enable));
          check_field("error_code", 8'(want.error_code), 8'(out_ch.item.error_code));
          check_field("bytes_left", want.bytes_left, out_ch.item.bytes_left);
          check_field("last", 8'(want.last), 8'(out_ch.item.last));
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("i2c_master_transfer_sequencer: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Source side: offer words in bursts of random length with random gaps;
  // a word marked for draining waits until no result is outstanding
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    if (in_taken) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (pending_words.size() == 0 ||
                 (pending_words[0].drain && expected_words.size() != 0)) begin
      in_ch.valid <= 1'b0;
    end else begin
      // hold valid high across back-to-back words; only the payload moves
      in_ch.valid <= 1'b1;
      in_ch.item  <= pending_words[0].word;
    end
  end

  // --------------------------------------------------------------------------
  // Sink side: stall in segments of changing pattern, and twice drop ready
  // for a long stretch so the block backs up into its input
  // --------------------------------------------------------------------------
  stall_mode_t stall_mode;
  int          stall_left;
  int          stall_phase;
  int          holdoff_left;
  int          holdoffs_done;
  int          next_holdoff_at;

  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else if (holdoffs_done < 2 && words_in >= next_holdoff_at) begin
      holdoff_left    = HOLDOFF_LEN - 1;
      holdoffs_done++;
      next_holdoff_at = next_holdoff_at + 200;
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_left <= 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(8, 60);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
        STALL_NONE:        out_ch.ready <= 1'b1;
        STALL_ONE_IN_FOUR: out_ch.ready <= (stall_phase % 4) != 0;
        STALL_COIN:        out_ch.ready <= 1'($urandom_range(0, 1));
        default:           out_ch.ready <= stall_phase[0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Run control
  // --------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.item      = '0;
    out_ch.ready    = 1'b0;
    seq             = '0;
    mismatches      = 0;
    words_in        = 0;
    idle_cycles     = 0;
    in_taken        = 1'b0;
    drain_next      = 1'b0;
    burst_left      = $urandom_range(1, 24);
    gap_left        = 0;
    stall_left      = 0;
    stall_phase     = 0;
    holdoff_left    = 0;
    holdoffs_done   = 0;
    next_holdoff_at = 120;

    build_directed();
    build_random();

    // release reset on a falling edge
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // wait for every word to go in and every result to come out
    while (pending_words.size() != 0) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("i2c_master_transfer_sequencer: match");
    else
      $display("i2c_master_transfer_sequencer: mismatch");
    $finish;
  end

endmodule

[files.f]
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_if.sv
hw/rtl/i2cm_step.sv
hw/rtl/i2cm_result_buf.sv
hw/rtl/i2c_master_transfer_sequencer.sv
tb/tb_i2c_master_transfer_sequencer.sv
